// File: hdl/svpwm_pkg.sv
package svpwm_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int SQRT3_Q16 = 113512;
  localparam logic [15:0] PERIOD_RESET = 16'd8400;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN   = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_DEAD   = 3'd2;
  localparam logic [2:0] REG_WINDOW = 3'd3;
  localparam logic [2:0] REG_LEAD   = 3'd4;

  // sampling strategies
  localparam logic [1:0] STRAT_NONE = 2'd0;
  localparam logic [1:0] STRAT_LATE = 2'd1;
  localparam logic [1:0] STRAT_MID  = 2'd2;
  localparam logic [1:0] STRAT_EARLY = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROJ, ST_MUL, ST_SUM, ST_DIV, ST_DUTY, ST_STRAT, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic proj;
    logic mul;
    logic sum;
    logic duty;
    logic strat;
  } cmd_t;

  typedef struct packed {
    logic over;
    logic div_done;
  } status_t;

endpackage

// File: hdl/svpwm_if.sv
interface svpwm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] v_alpha;
  logic signed [15:0] v_beta;
  modport source(output valid, v_alpha, v_beta, input ready);
  modport sink(input valid, v_alpha, v_beta, output ready);
endinterface

interface svpwm_out_if;
  logic valid;
  logic ready;
  logic [2:0] sector;
  logic [15:0] duty_u;
  logic [15:0] duty_v;
  logic [15:0] duty_w;
  logic overmodulated;
  logic sample_changed;
  logic signed [17:0] sample_point;
  modport source(output valid, sector, duty_u, duty_v, duty_w, overmodulated,
                 sample_changed, sample_point, input ready);
  modport sink(input valid, sector, duty_u, duty_v, duty_w, overmodulated,
               sample_changed, sample_point, output ready);
endinterface

// File: hdl/svpwm_sector_duty_and_sample_point.sv
// channel | dir | beat contents
// in      | in  | v_alpha, v_beta
// out     | out | sector, duty_u/v/w, overmodulated, sample_changed, sample_point
// cfg     | in  | cfg_we, cfg_index, cfg_data (no handshake)
// A result follows the projection, gain, sum, divide, duty and strategy states;
// the divide waits on the bit-serial divider only when overmodulated. Items go
// one at a time; the next input can be taken in the cycle after the result beat.
// Reset is synchronous, active high; config returns to reset values.
// A stalled result holds until taken; input is refused meanwhile.
module svpwm_sector_duty_and_sample_point (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [31:0] cfg_data,
  svpwm_in_if.sink in_ch,
  svpwm_out_if.source out_ch
);

  svpwm_pkg::cmd_t cmd;
  svpwm_pkg::status_t status;

  svpwm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .status(status)
  );

  svpwm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .v_alpha(in_ch.v_alpha), .v_beta(in_ch.v_beta),
    .sector(out_ch.sector), .duty_u(out_ch.duty_u), .duty_v(out_ch.duty_v),
    .duty_w(out_ch.duty_w), .overmodulated(out_ch.overmodulated),
    .sample_changed(out_ch.sample_changed), .sample_point(out_ch.sample_point)
  );

endmodule

// File: hdl/svpwm_ctrl.sv
module svpwm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output svpwm_pkg::cmd_t cmd,
  input  svpwm_pkg::status_t status
);

  svpwm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= svpwm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      svpwm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = svpwm_pkg::ST_PROJ;
        end
      end
      svpwm_pkg::ST_PROJ: begin
        cmd.proj = 1'b1;
        state_next = svpwm_pkg::ST_MUL;
      end
      svpwm_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = svpwm_pkg::ST_SUM;
      end
      svpwm_pkg::ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = svpwm_pkg::ST_DIV;
      end
      svpwm_pkg::ST_DIV: begin
        if (!status.over) state_next = svpwm_pkg::ST_DUTY;
        else if (status.div_done) state_next = svpwm_pkg::ST_DUTY;
      end
      svpwm_pkg::ST_DUTY: begin
        cmd.duty = 1'b1;
        state_next = svpwm_pkg::ST_STRAT;
      end
      svpwm_pkg::ST_STRAT: begin
        cmd.strat = 1'b1;
        state_next = svpwm_pkg::ST_OUT;
      end
      svpwm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = svpwm_pkg::ST_IDLE;
      end
      default: state_next = svpwm_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.proj)
    else $error("load not followed by projection");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");

endmodule

// File: hdl/svpwm_dp.sv
module svpwm_dp (
  input  logic clk,
  input  logic rst,
  input  svpwm_pkg::cmd_t cmd,
  output svpwm_pkg::status_t status,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic signed [15:0] v_alpha,
  input  logic signed [15:0] v_beta,
  output logic [2:0] sector,
  output logic [15:0] duty_u,
  output logic [15:0] duty_v,
  output logic [15:0] duty_w,
  output logic overmodulated,
  output logic sample_changed,
  output logic signed [17:0] sample_point
);

  localparam int DMAX = (1 << svpwm_pkg::TICK_WIDTH) - 1;

  logic [31:0] gain;
  logic [15:0] period, dead, lead;
  logic [16:0] window;
  logic [1:0] strategy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
      period <= svpwm_pkg::PERIOD_RESET;
      dead <= '0;
      window <= '0;
      lead <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        svpwm_pkg::REG_GAIN: gain <= cfg_data;
        svpwm_pkg::REG_PERIOD: period <= cfg_data[15:0];
        svpwm_pkg::REG_DEAD: dead <= cfg_data[15:0];
        svpwm_pkg::REG_WINDOW: window <= cfg_data[16:0];
        svpwm_pkg::REG_LEAD: lead <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // projections, Q.31 values after sector selection
  logic signed [15:0] a, b;
  logic signed [35:0] px, py;
  logic [2:0] sec;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= v_alpha;
      b <= v_beta;
    end
  end

  logic signed [35:0] u1c, u2c, u3c;
  logic [2:0] nsel;
  always_comb begin
    u1c = 36'(b) <<< 16;
    u2c = 36'(a) * 36'(svpwm_pkg::SQRT3_Q16) - u1c;
    u3c = -u2c - (u1c <<< 1);
    nsel = {u3c > 0, u2c > 0, u1c > 0};
  end

  always_ff @(posedge clk) begin
    if (cmd.proj) begin
      case (nsel)
        3'd1: begin px <= -u3c; py <= -(u1c <<< 1); sec <= 3'd2; end
        3'd2: begin px <= u3c; py <= u2c; sec <= 3'd6; end
        3'd3: begin px <= -u2c; py <= -u3c; sec <= 3'd1; end
        3'd4: begin px <= -(u1c <<< 1); py <= -u2c; sec <= 3'd4; end
        3'd5: begin px <= u2c; py <= (u1c <<< 1); sec <= 3'd3; end
        3'd6: begin px <= (u1c <<< 1); py <= u3c; sec <= 3'd5; end
        default: begin px <= '0; py <= '0; sec <= 3'd0; end
      endcase
    end
  end

  // scale by gain: trunc toward zero of k*u / 2^47
  function automatic logic signed [35:0] scale(input logic signed [35:0] u,
                                                input logic [31:0] k);
    logic [35:0] m;
    logic [68:0] hi;
    logic [67:0] lo;
    logic [68:0] q;
    begin
      m = u[35] ? 36'(-u) : 36'(u);
      hi = 69'(k[31:16]) * 69'(m);
      lo = (68'(k[15:0]) * 68'(m)) >> 16;
      q = (hi + 69'(lo)) >> 31;
      scale = u[35] ? -36'(q) : 36'(q);
    end
  endfunction

  logic signed [35:0] tx, ty;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      tx <= scale(px, gain);
      ty <= scale(py, gain);
    end
  end

  // overmodulation divider: restoring, one quotient bit a cycle
  logic over;
  logic [5:0] cnt;
  logic [53:0] nx, ny, qx, qy;
  logic [54:0] rx, ry;
  logic busy;
  logic [35:0] den;
  logic signed [35:0] txo, tyo;
  logic [54:0] rxs, rys;

  assign status.over = over;
  assign status.div_done = !busy && over;

  always_comb begin
    rxs = {rx[53:0], nx[53]};
    rys = {ry[53:0], ny[53]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.sum) begin
      over <= (tx + ty) > $signed({20'd0, period});
      busy <= (tx + ty) > $signed({20'd0, period});
      den <= 36'(tx + ty);
      nx <= 54'(tx[35] ? -tx : tx) * 54'(period);
      ny <= 54'(ty[35] ? -ty : ty) * 54'(period);
      rx <= '0; ry <= '0; qx <= '0; qy <= '0;
      cnt <= 6'd54;
      txo <= tx; tyo <= ty;
    end else if (busy) begin
      nx <= nx << 1; ny <= ny << 1;
      if (rxs >= 55'(den)) begin rx <= rxs - 55'(den); qx <= {qx[52:0], 1'b1}; end
      else begin rx <= rxs; qx <= {qx[52:0], 1'b0}; end
      if (rys >= 55'(den)) begin ry <= rys - 55'(den); qy <= {qy[52:0], 1'b1}; end
      else begin ry <= rys; qy <= {qy[52:0], 1'b0}; end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  // compare values
  function automatic logic [15:0] to_duty(input logic signed [39:0] num);
    logic signed [39:0] d;
    begin
      d = num >>> 2;
      if (num < 0) to_duty = '0;
      else if (d > 40'(DMAX)) to_duty = 16'(DMAX);
      else to_duty = d[15:0];
    end
  endfunction

  logic signed [39:0] ftx, fty, ftz, qout, qin, qoff;
  always_comb begin
    if (over) begin
      ftx = txo[35] ? -40'(qx) : 40'(qx);
      fty = tyo[35] ? -40'(qy) : 40'(qy);
      ftz = '0;
    end else begin
      ftx = 40'(txo);
      fty = 40'(tyo);
      ftz = 40'(period) - 40'(txo) - 40'(tyo);
    end
    qout = 3 * ftz + 2 * ftx + 2 * fty;
    qin = 2 * ftz + 4 * ftx + 2 * fty;
    qoff = 40'(period) <<< 1;
  end

  // route outer, inner and idle values to the phases of the sector
  logic [15:0] dout, din, doff;
  logic [15:0] du_next, dv_next, dw_next;
  always_comb begin
    dout = to_duty(qout);
    din = to_duty(qin);
    doff = to_duty(qoff);
    du_next = doff;
    dv_next = doff;
    dw_next = doff;
    case (sec)
      3'd1: begin du_next = dout; dv_next = din; end
      3'd2: begin du_next = din; dv_next = dout; end
      3'd3: begin dv_next = dout; dw_next = din; end
      3'd4: begin dv_next = din; dw_next = dout; end
      3'd5: begin du_next = din; dw_next = dout; end
      3'd6: begin du_next = dout; dw_next = din; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.duty) begin
      sector <= sec;
      overmodulated <= over;
      duty_u <= du_next;
      duty_v <= dv_next;
      duty_w <= dw_next;
    end
  end

  // sampling strategy
  logic [15:0] c;
  logic [1:0] strat;
  logic signed [17:0] point_next;
  always_comb begin
    if (sector == 3'd1 || sector == 3'd4) c = duty_u;
    else if (sector == 3'd2 || sector == 3'd5) c = duty_v;
    else c = duty_w;
    if (c > dead) strat = svpwm_pkg::STRAT_LATE;
    else if (window > {c, 1'b0}) strat = svpwm_pkg::STRAT_EARLY;
    else strat = svpwm_pkg::STRAT_MID;
    case (strat)
      svpwm_pkg::STRAT_LATE: point_next = 18'sd1;
      svpwm_pkg::STRAT_MID: point_next = 18'({2'b0, duty_u} - {2'b0, lead});
      default: point_next = 18'({2'b0, duty_u} + {2'b0, dead});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= svpwm_pkg::STRAT_NONE;
    end else if (cmd.strat) begin
      sample_changed <= strat != strategy;
      sample_point <= (strat != strategy) ? point_next : '0;
      if (strat != strategy) strategy <= strat;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.sum |=> !busy || over)
    else $error("divider busy without overmodulation");
  assert property (@(posedge clk) disable iff (rst)
    cmd.strat |=> (sample_changed == 1'b0) || (strategy != svpwm_pkg::STRAT_NONE))
    else $error("strategy change to none");
  assert property (@(posedge clk) disable iff (rst) cmd.duty |=> sector <= 3'd6)
    else $error("bad sector");

endmodule
